>>> sv/chunked_body_decoder_top_assert.svh
// assertion macros for the chunked body decoder checker
`ifndef CHUNKED_BODY_DECODER_TOP_ASSERT_SVH
`define CHUNKED_BODY_DECODER_TOP_ASSERT_SVH

// checked while out of reset
`define CBD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("chunked body decoder check failed");

// checked on every edge, reset included
`define CBD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("chunked body decoder check failed");

`endif

>>> sv/cbd_pkg.sv
// types and constants shared by the chunked body decoder
package cbd_pkg;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam logic [1:0] ST_BUSY = 2'd0;
   localparam logic [1:0] ST_DONE = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   localparam logic [1:0] SKIP_BYTES = 2'd2;

   typedef enum logic [2:0] {
      PH_SIZE    = 3'd0,
      PH_SIZE_LF = 3'd1,
      PH_DATA    = 3'd2,
      PH_SKIP    = 3'd3,
      PH_END_CR  = 3'd4,
      PH_END_LF  = 3'd5,
      PH_DONE    = 3'd6,
      PH_ERROR   = 3'd7
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_body;
   } req_type;

   typedef struct packed {
      logic [7:0] body_byte;
      logic       is_payload;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      phase_type  phase;
      logic [1:0] skip_count;
   } ctl_type;

endpackage

>>> sv/cbd_step.sv
// next-state and result logic for one byte of the chunked body
module cbd_step
   import cbd_pkg::*;
#(
   parameter int SIZE_WIDTH = 32
) (
   input  req_type                 item,
   input  ctl_type                 ctl_cur,
   input  logic [SIZE_WIDTH-1:0]   size_acc_cur,
   input  logic [SIZE_WIDTH-1:0]   bytes_rem_cur,
   output ctl_type                 ctl_nxt,
   output logic [SIZE_WIDTH-1:0]   size_acc_nxt,
   output logic [SIZE_WIDTH-1:0]   bytes_rem_nxt,
   output rsp_type                 result
);

   ctl_type               ctl_start;
   logic [SIZE_WIDTH-1:0] acc_start;
   logic [SIZE_WIDTH-1:0] rem_start;
   logic [7:0]            c;
   logic                  is_hex;
   logic [3:0]            digit;
   logic                  payload;
   logic [SIZE_WIDTH-1:0] rem_dec;
   logic [1:0]            skip_dec;

   assign c = item.data_byte;

   // new body starts from reset state
   always_comb begin
      if (item.new_body) begin
         ctl_start.phase      = PH_SIZE;
         ctl_start.skip_count = '0;
         acc_start            = '0;
         rem_start            = '0;
      end else begin
         ctl_start = ctl_cur;
         acc_start = size_acc_cur;
         rem_start = bytes_rem_cur;
      end
   end

   // hex digit decode
   always_comb begin
      is_hex = 1'b1;
      digit  = 4'd0;
      if (c >= "0" && c <= "9") begin
         digit = 4'(c - "0");
      end else if (c >= "a" && c <= "f") begin
         digit = 4'(c - "a" + 8'd10);
      end else if (c >= "A" && c <= "F") begin
         digit = 4'(c - "A" + 8'd10);
      end else begin
         is_hex = 1'b0;
      end
   end

   assign rem_dec  = rem_start - 1'b1;
   assign skip_dec = ctl_start.skip_count - 1'b1;

   always_comb begin
      ctl_nxt       = ctl_start;
      size_acc_nxt  = acc_start;
      bytes_rem_nxt = rem_start;
      payload       = 1'b0;
      case (ctl_start.phase)
         PH_SIZE: begin
            if (is_hex) begin
               // top digit already used: one more would overflow
               if (acc_start[SIZE_WIDTH-1 -: 4] != 4'd0) begin
                  ctl_nxt.phase = PH_ERROR;
               end else begin
                  size_acc_nxt = {acc_start[SIZE_WIDTH-5:0], digit};
               end
            end else if (c == CHAR_CR) begin
               ctl_nxt.phase = PH_SIZE_LF;
            end else begin
               ctl_nxt.phase = PH_ERROR;
            end
         end
         PH_SIZE_LF: begin
            if (c != CHAR_LF) begin
               ctl_nxt.phase = PH_ERROR;
            end else if (acc_start == '0) begin
               ctl_nxt.phase = PH_END_CR;
            end else begin
               bytes_rem_nxt = acc_start;
               size_acc_nxt  = '0;
               ctl_nxt.phase = PH_DATA;
            end
         end
         PH_DATA: begin
            payload       = 1'b1;
            bytes_rem_nxt = rem_dec;
            if (rem_dec == '0) begin
               ctl_nxt.skip_count = SKIP_BYTES;
               ctl_nxt.phase      = PH_SKIP;
            end
         end
         PH_SKIP: begin
            ctl_nxt.skip_count = skip_dec;
            if (skip_dec == 2'd0) begin
               size_acc_nxt  = '0;
               ctl_nxt.phase = PH_SIZE;
            end
         end
         PH_END_CR: begin
            ctl_nxt.phase = (c == CHAR_CR) ? PH_END_LF : PH_ERROR;
         end
         PH_END_LF: begin
            ctl_nxt.phase = (c == CHAR_LF) ? PH_DONE : PH_ERROR;
         end
         PH_DONE: begin
            ctl_nxt.phase = PH_DONE;
         end
         default: begin
            ctl_nxt.phase = PH_ERROR;
         end
      endcase
   end

   always_comb begin
      result.is_payload = payload;
      result.body_byte  = payload ? c : 8'd0;
      if (ctl_nxt.phase == PH_DONE) begin
         result.status = ST_DONE;
      end else if (ctl_nxt.phase == PH_ERROR) begin
         result.status = ST_BAD;
      end else begin
         result.status = ST_BUSY;
      end
   end

endmodule

>>> sv/chunked_body_decoder_top.sv
// chunked body decoder: top level with input and result registers
// an accepted transaction passes the input register, then the result register, on its way to rsp
// throughput: one byte per cycle while rsp_stall is low, the single state update sits between two registers
// rsp_stall holds the result register; the input register keeps taking bytes until full
// reset (synchronous, active high) empties both registers and returns the decoder
// to the start of a size line with zero size
module chunked_body_decoder_top
   import cbd_pkg::*;
#(
   parameter int SIZE_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // input register
   logic                  in_vld_ff;
   logic                  in_vld_in;
   req_type               in_data_ff;

   // decoder state
   ctl_type               ctl_ff;
   ctl_type               ctl_in;
   logic [SIZE_WIDTH-1:0] size_acc_ff;
   logic [SIZE_WIDTH-1:0] size_acc_in;
   logic [SIZE_WIDTH-1:0] bytes_rem_ff;
   logic [SIZE_WIDTH-1:0] bytes_rem_in;

   // result register
   logic                  out_vld_ff;
   logic                  out_vld_in;
   rsp_type               out_data_ff;
   rsp_type               out_data_in;

   logic                  accept;
   logic                  advance;

   // the held byte moves on when the result register is empty or being drained
   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
   end

   always_comb begin
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (out_vld_ff && !rsp_stall) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   cbd_step #(
      .SIZE_WIDTH (SIZE_WIDTH)
   ) u_step (
      .item          (in_data_ff),
      .ctl_cur       (ctl_ff),
      .size_acc_cur  (size_acc_ff),
      .bytes_rem_cur (bytes_rem_ff),
      .ctl_nxt       (ctl_in),
      .size_acc_nxt  (size_acc_in),
      .bytes_rem_nxt (bytes_rem_in),
      .result        (out_data_in)
   );

   // handshake flags and decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff           <= 1'b0;
         out_vld_ff          <= 1'b0;
         ctl_ff.phase        <= PH_SIZE;
         ctl_ff.skip_count   <= '0;
         size_acc_ff         <= '0;
         bytes_rem_ff        <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         // state only moves when a byte is actually decoded
         if (advance) begin
            ctl_ff       <= ctl_in;
            size_acc_ff  <= size_acc_in;
            bytes_rem_ff <= bytes_rem_in;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

endmodule

>>> sv/cbd_checker.sv
// port-level checks for the chunked body decoder and their bind
`include "chunked_body_decoder_top_assert.svh"

module cbd_checker
   import cbd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // nothing comes out right after reset
   `CBD_ASSERT_ALWAYS(a_rst_empty, clock, reset |=> !rsp_valid)

   // payload bytes only appear while a body is still in progress
   `CBD_ASSERT(a_payload_busy, clock, reset, rsp_valid && rsp_data.is_payload |-> rsp_data.status == ST_BUSY)

   // non-payload transactions carry a zero byte
   `CBD_ASSERT(a_zero_byte, clock, reset, rsp_valid && !rsp_data.is_payload |-> rsp_data.body_byte == 8'd0)

   // a stalled result holds
   `CBD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))

endmodule

bind chunked_body_decoder_top cbd_checker u_cbd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
